// ===== rtl/twist_to_wheel_duty_mixer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// twist_to_wheel_duty_mixer_unit_defines
// assertion macros used by the checker file of the mixer
// ----------------------------------------------------------------------------
`ifndef TWIST_TO_WHEEL_DUTY_MIXER_UNIT_DEFINES_SVH
`define TWIST_TO_WHEEL_DUTY_MIXER_UNIT_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define TWDM_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("twdm check failed");

// next-cycle implication on clk, off during reset
`define TWDM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("twdm check failed");

`endif

// ===== rtl/twdm_pkg.sv =====
// ----------------------------------------------------------------------------
// twdm_pkg
// types, constants and codes of the twist to wheel duty mixer
// ----------------------------------------------------------------------------
package twdm_pkg;

    localparam int SPEED_W   = 16;
    localparam int DB_W      = 15;
    localparam int GAIN_W    = 16;
    localparam int TRACK_W   = 12;
    localparam int ALPHA_W   = 9;
    localparam int FLOORS_W  = 16;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int A_W   = 20;
    localparam int B_W   = 18;
    localparam int P_W   = A_W + B_W;
    localparam int C_W   = 16;
    localparam int SH_W  = 4;
    localparam int REM_W = 24;
    localparam int CNT_W = 3;
    localparam int DIV_STEPS = 8;

    localparam logic [C_W-1:0]  RND_Q12 = 16'd2048;
    localparam logic [C_W-1:0]  RND_Q8  = 16'd128;
    localparam logic [SH_W-1:0] SH_Q12  = 4'd12;
    localparam logic [SH_W-1:0] SH_Q8   = 4'd8;
    localparam logic [SH_W-1:0] SH_NONE = 4'd0;
    localparam logic [B_W-1:0]  DUTY_SCALE = 18'd510;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    localparam logic [DB_W-1:0]     RST_LINEAR_DB  = 15'd82;
    localparam logic [DB_W-1:0]     RST_ANGULAR_DB = 15'd205;
    localparam logic [GAIN_W-1:0]   RST_GAIN       = 16'hD000;
    localparam logic [TRACK_W-1:0]  RST_HALF_TRACK = 12'd246;
    localparam logic [DB_W-1:0]     RST_SPIN_FLOOR = 15'd328;
    localparam logic [DB_W-1:0]     RST_MAX_SPEED  = 15'd991;
    localparam logic [ALPHA_W-1:0]  RST_ALPHA      = 9'd64;
    localparam logic [FLOORS_W-1:0] RST_FLOORS     = 16'd20510;

    localparam bit DEF_LEFT_INVERT  = 1'b1;
    localparam bit DEF_RIGHT_INVERT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINEAR_DB  = 3'd0,
        CFG_ANGULAR_DB = 3'd1,
        CFG_GAIN       = 3'd2,
        CFG_HALF_TRACK = 3'd3,
        CFG_SPIN_FLOOR = 3'd4,
        CFG_MAX_SPEED  = 3'd5,
        CFG_ALPHA      = 3'd6,
        CFG_FLOORS     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DB_W-1:0]     linear_db;
        logic [DB_W-1:0]     angular_db;
        logic [GAIN_W-1:0]   gain;
        logic [TRACK_W-1:0]  half_track;
        logic [DB_W-1:0]     spin_floor;
        logic [DB_W-1:0]     max_speed;
        logic [ALPHA_W-1:0]  alpha;
        logic [FLOORS_W-1:0] floors;
    } cfg_t;

    typedef enum logic [1:0] {
        ALU_NOP = 2'd0,
        ALU_MAC = 2'd1,
        ALU_DIV = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [A_W-1:0]   a;
        logic [B_W-1:0]   b;
        logic [C_W-1:0]   c;
        logic [SH_W-1:0]  sh;
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dvs;
    } alu_req_t;

    typedef struct packed {
        logic [P_W-1:0]   mac;
        logic [REM_W-1:0] rem;
        logic             qbit;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_MUL_W  = 4'd1,
        ST_MUL_H  = 4'd2,
        ST_MIX    = 4'd3,
        ST_CLAMP  = 4'd4,
        ST_DIFF   = 4'd5,
        ST_FILT_L = 4'd6,
        ST_FILT_R = 4'd7,
        ST_CMD    = 4'd8,
        ST_NUM_L  = 4'd9,
        ST_DIV_L  = 4'd10,
        ST_NUM_R  = 4'd11,
        ST_DIV_R  = 4'd12,
        ST_DONE   = 4'd13
    } state_t;

endpackage

// ===== rtl/twdm_alu.sv =====
// ----------------------------------------------------------------------------
// twdm_alu
// shared multiply-add-round unit and restoring divide step
// ----------------------------------------------------------------------------
module twdm_alu
    import twdm_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic signed [P_W-1:0] prod;
    logic signed [P_W-1:0] sum;
    logic                  ge;

    always_comb
    begin
        prod     = signed'(req.a) * signed'(req.b);
        sum      = prod + signed'({{(P_W-C_W){1'b0}}, req.c});
        ge       = (req.rem >= req.dvs);
        rsp.mac  = '0;
        rsp.rem  = req.rem;
        rsp.qbit = 1'b0;
        case (req.op)
            ALU_MAC:
            begin
                rsp.mac = sum >>> req.sh;
            end
            ALU_DIV:
            begin
                rsp.qbit = ge;
                rsp.rem  = ge ? (req.rem - req.dvs) : req.rem;
            end
            default:
            begin
                rsp.mac = '0;
            end
        endcase
    end

endmodule

// ===== rtl/twdm_seq.sv =====
// ----------------------------------------------------------------------------
// twdm_seq
// sequencer and datapath registers, drives the shared alu one step a cycle
// ----------------------------------------------------------------------------
module twdm_seq
    import twdm_pkg::*;
#(
    parameter bit LEFT_INVERT  = DEF_LEFT_INVERT,
    parameter bit RIGHT_INVERT = DEF_RIGHT_INVERT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SPEED_W-1:0] linear_speed,
    input  logic [SPEED_W-1:0] angular_speed,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DUTY_W-1:0]  left_duty,
    output logic               left_forward,
    output logic [DUTY_W-1:0]  right_duty,
    output logic               right_forward,
    output logic               spin_active,
    output alu_req_t           alu_req,
    input  alu_rsp_t           alu_rsp
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0] filt_l_reg, filt_l_next, filt_r_reg, filt_r_next;

    logic [SPEED_W-1:0] v_reg, v_next, wz_reg, wz_next;
    logic [A_W-1:0] w_reg, w_next, h_reg, h_next;
    logic [A_W:0] vl_reg, vl_next, vr_reg, vr_next;
    logic [SPEED_W-1:0] tl_reg, tl_next, tr_reg, tr_next;
    logic [SPEED_W:0] dl_reg, dl_next, dr_reg, dr_next;
    logic spin_reg, spin_next;
    logic [DB_W-1:0] ml_reg, ml_next, mr_reg, mr_next;
    logic fl_reg, fl_next, fr_reg, fr_next;
    logic [REM_W-1:0] rem_reg, rem_next, dvs_reg, dvs_next;
    logic [DUTY_W-1:0] quo_reg, quo_next, ql_reg, ql_next;
    logic [DUTY_W-1:0] ld_reg, ld_next, rd_reg, rd_next;
    logic lf_reg, lf_next, rf_reg, rf_next, sp_reg, sp_next;

    function automatic logic [SPEED_W-1:0] deadband(input logic [SPEED_W-1:0] x,
                                                    input logic [DB_W-1:0] db);
        logic [SPEED_W:0] ext;
        logic [SPEED_W:0] mag;
        ext = {x[SPEED_W-1], x};
        mag = x[SPEED_W-1] ? (17'd0 - ext) : ext;
        return (mag < {2'b00, db}) ? '0 : x;
    endfunction

    function automatic logic [SPEED_W-1:0] clamp(input logic signed [A_W:0] x,
                                                 input logic [DB_W-1:0] lim);
        logic signed [A_W:0] hi;
        logic signed [A_W:0] lo;
        logic signed [A_W:0] r;
        hi = signed'({6'd0, lim});
        lo = -hi;
        r  = x;
        if (x > hi)
        begin
            r = hi;
        end
        else if (x < lo)
        begin
            r = lo;
        end
        return r[SPEED_W-1:0];
    endfunction

    function automatic logic [SPEED_W:0] wheel_cmd(input logic [SPEED_W-1:0] f,
                                                   input bit inv);
        logic [SPEED_W:0] ext;
        ext = {f[SPEED_W-1], f};
        return inv ? (17'd0 - ext) : ext;
    endfunction

    function automatic logic [DB_W-1:0] sat_mag(input logic [SPEED_W:0] c,
                                                input logic [DB_W-1:0] lim);
        logic [SPEED_W:0] mag;
        mag = c[SPEED_W] ? (17'd0 - c) : c;
        return (mag > {2'b00, lim}) ? lim : mag[DB_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] raise(input logic [DUTY_W-1:0] q,
                                                input logic [DUTY_W-1:0] fl);
        return ((q != '0) && (q < fl)) ? fl : q;
    endfunction

    always_comb
    begin
        logic signed [A_W:0] v21;
        logic signed [A_W:0] h21;
        logic signed [A_W:0] habs;
        logic signed [A_W:0] flr;
        logic signed [A_W:0] t;
        logic [ALPHA_W-1:0]  alpha_eff;
        logic [DB_W-1:0]     dv;
        logic [SPEED_W:0]    cl;
        logic [SPEED_W:0]    cr;
        logic [DUTY_W-1:0]   qsh;
        logic [DUTY_W-1:0]   dfl;

        state_next = state_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        filt_l_next = filt_l_reg;
        filt_r_next = filt_r_reg;
        v_next = v_reg;
        wz_next = wz_reg;
        w_next = w_reg;
        h_next = h_reg;
        vl_next = vl_reg;
        vr_next = vr_reg;
        tl_next = tl_reg;
        tr_next = tr_reg;
        dl_next = dl_reg;
        dr_next = dr_reg;
        spin_next = spin_reg;
        ml_next = ml_reg;
        mr_next = mr_reg;
        fl_next = fl_reg;
        fr_next = fr_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        ql_next = ql_reg;
        ld_next = ld_reg;
        rd_next = rd_reg;
        lf_next = lf_reg;
        rf_next = rf_reg;
        sp_next = sp_reg;

        alu_req = '0;
        alu_req.op = ALU_NOP;

        v21 = signed'({{5{v_reg[SPEED_W-1]}}, v_reg});
        h21 = signed'({h_reg[A_W-1], h_reg});
        habs = h21[A_W] ? -h21 : h21;
        flr = signed'({6'd0, cfg.spin_floor});
        t = (habs < flr) ? flr : habs;
        alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
        dv = (cfg.max_speed == '0) ? 15'd1 : cfg.max_speed;
        cl = wheel_cmd(filt_l_reg, LEFT_INVERT);
        cr = wheel_cmd(filt_r_reg, RIGHT_INVERT);
        qsh = {quo_reg[DUTY_W-2:0], alu_rsp.qbit};
        dfl = spin_reg ? cfg.floors[15:8] : cfg.floors[7:0];

        in_ready = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    v_next = deadband(linear_speed, cfg.linear_db);
                    wz_next = deadband(angular_speed, cfg.angular_db);
                    state_next = ST_MUL_W;
                end
            end
            ST_MUL_W:
            begin
                alu_req.op = ALU_MAC;
                alu_req.a = {{(A_W-GAIN_W){cfg.gain[GAIN_W-1]}}, cfg.gain};
                alu_req.b = {{(B_W-SPEED_W){wz_reg[SPEED_W-1]}}, wz_reg};
                alu_req.c = RND_Q12;
                alu_req.sh = SH_Q12;
                w_next = alu_rsp.mac[A_W-1:0];
                state_next = ST_MUL_H;
            end
            ST_MUL_H:
            begin
                alu_req.op = ALU_MAC;
                alu_req.a = w_reg;
                alu_req.b = {{(B_W-TRACK_W){1'b0}}, cfg.half_track};
                alu_req.c = RND_Q12;
                alu_req.sh = SH_Q12;
                h_next = alu_rsp.mac[A_W-1:0];
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                spin_next = (v_reg == '0) && (w_reg != '0);
                if ((v_reg == '0) && (w_reg != '0))
                begin
                    if (!w_reg[A_W-1])
                    begin
                        vl_next = -t;
                        vr_next = t;
                    end
                    else
                    begin
                        vl_next = t;
                        vr_next = -t;
                    end
                end
                else
                begin
                    vl_next = v21 - h21;
                    vr_next = v21 + h21;
                end
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                tl_next = clamp(signed'(vl_reg), cfg.max_speed);
                tr_next = clamp(signed'(vr_reg), cfg.max_speed);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dl_next = {tl_reg[SPEED_W-1], tl_reg} - {filt_l_reg[SPEED_W-1], filt_l_reg};
                dr_next = {tr_reg[SPEED_W-1], tr_reg} - {filt_r_reg[SPEED_W-1], filt_r_reg};
                state_next = ST_FILT_L;
            end
            ST_FILT_L:
            begin
                alu_req.op = ALU_MAC;
                alu_req.a = {{(A_W-ALPHA_W){1'b0}}, alpha_eff};
                alu_req.b = {dl_reg[SPEED_W], dl_reg};
                alu_req.c = RND_Q8;
                alu_req.sh = SH_Q8;
                filt_l_next = filt_l_reg + alu_rsp.mac[SPEED_W-1:0];
                state_next = ST_FILT_R;
            end
            ST_FILT_R:
            begin
                alu_req.op = ALU_MAC;
                alu_req.a = {{(A_W-ALPHA_W){1'b0}}, alpha_eff};
                alu_req.b = {dr_reg[SPEED_W], dr_reg};
                alu_req.c = RND_Q8;
                alu_req.sh = SH_Q8;
                filt_r_next = filt_r_reg + alu_rsp.mac[SPEED_W-1:0];
                state_next = ST_CMD;
            end
            ST_CMD:
            begin
                fl_next = !cl[SPEED_W];
                fr_next = !cr[SPEED_W];
                ml_next = sat_mag(cl, cfg.max_speed);
                mr_next = sat_mag(cr, cfg.max_speed);
                state_next = ST_NUM_L;
            end
            ST_NUM_L, ST_NUM_R:
            begin
                alu_req.op = ALU_MAC;
                alu_req.a = {{(A_W-DB_W){1'b0}}, (state_reg == ST_NUM_L) ? ml_reg : mr_reg};
                alu_req.b = DUTY_SCALE;
                alu_req.c = {1'b0, dv};
                alu_req.sh = SH_NONE;
                rem_next = alu_rsp.mac[REM_W-1:0];
                dvs_next = {{(REM_W-DB_W){1'b0}}, dv} << DIV_STEPS;
                quo_next = '0;
                cnt_next = '0;
                state_next = (state_reg == ST_NUM_L) ? ST_DIV_L : ST_DIV_R;
            end
            ST_DIV_L, ST_DIV_R:
            begin
                alu_req.op = ALU_DIV;
                alu_req.rem = rem_reg;
                alu_req.dvs = dvs_reg;
                rem_next = alu_rsp.rem;
                dvs_next = dvs_reg >> 1;
                quo_next = qsh;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    if (state_reg == ST_DIV_L)
                    begin
                        ql_next = qsh;
                        state_next = ST_NUM_R;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ld_next = raise(ql_reg, dfl);
                    rd_next = raise(quo_reg, dfl);
                    lf_next = fl_reg;
                    rf_next = fr_reg;
                    sp_next = spin_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            filt_l_reg <= '0;
            filt_r_reg <= '0;
            sp_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
            filt_l_reg <= filt_l_next;
            filt_r_reg <= filt_r_next;
            sp_reg <= sp_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        wz_reg <= wz_next;
        w_reg <= w_next;
        h_reg <= h_next;
        vl_reg <= vl_next;
        vr_reg <= vr_next;
        tl_reg <= tl_next;
        tr_reg <= tr_next;
        dl_reg <= dl_next;
        dr_reg <= dr_next;
        spin_reg <= spin_next;
        ml_reg <= ml_next;
        mr_reg <= mr_next;
        fl_reg <= fl_next;
        fr_reg <= fr_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        ql_reg <= ql_next;
        ld_reg <= ld_next;
        rd_reg <= rd_next;
        lf_reg <= lf_next;
        rf_reg <= rf_next;
    end

    assign out_valid = out_valid_reg;
    assign left_duty = ld_reg;
    assign right_duty = rd_reg;
    assign left_forward = lf_reg;
    assign right_forward = rf_reg;
    assign spin_active = sp_reg;

endmodule

// ===== rtl/twist_to_wheel_duty_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// twist_to_wheel_duty_mixer_unit
// velocity command to left and right wheel duty with direction bits
// ----------------------------------------------------------------------------
// A single shared multiplier handles the gain, track, two filter and two
// duty scaling products one per cycle, and each wheel's duty quotient comes
// from eight restoring divide steps on the same unit. The result sits in an
// output register; a new command is accepted as soon as the result is
// loaded, even while it still waits to be taken. Settings are written
// through the cfg port; the user must write them only while idle, as the
// block itself does not enforce it.
module twist_to_wheel_duty_mixer_unit
    import twdm_pkg::*;
#(
    parameter bit LEFT_INVERT  = DEF_LEFT_INVERT,
    parameter bit RIGHT_INVERT = DEF_RIGHT_INVERT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SPEED_W-1:0]    linear_speed,
    input  logic [SPEED_W-1:0]    angular_speed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DUTY_W-1:0]     left_duty,
    output logic                  left_forward,
    output logic [DUTY_W-1:0]     right_duty,
    output logic                  right_forward,
    output logic                  spin_active
);

    cfg_t cfg_reg, cfg_next;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LINEAR_DB:  cfg_next.linear_db = cfg_data[DB_W-1:0];
                CFG_ANGULAR_DB: cfg_next.angular_db = cfg_data[DB_W-1:0];
                CFG_GAIN:       cfg_next.gain = cfg_data[GAIN_W-1:0];
                CFG_HALF_TRACK: cfg_next.half_track = cfg_data[TRACK_W-1:0];
                CFG_SPIN_FLOOR: cfg_next.spin_floor = cfg_data[DB_W-1:0];
                CFG_MAX_SPEED:  cfg_next.max_speed = cfg_data[DB_W-1:0];
                CFG_ALPHA:      cfg_next.alpha = cfg_data[ALPHA_W-1:0];
                CFG_FLOORS:     cfg_next.floors = cfg_data[FLOORS_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_db <= RST_LINEAR_DB;
            cfg_reg.angular_db <= RST_ANGULAR_DB;
            cfg_reg.gain <= RST_GAIN;
            cfg_reg.half_track <= RST_HALF_TRACK;
            cfg_reg.spin_floor <= RST_SPIN_FLOOR;
            cfg_reg.max_speed <= RST_MAX_SPEED;
            cfg_reg.alpha <= RST_ALPHA;
            cfg_reg.floors <= RST_FLOORS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    twdm_seq #(
        .LEFT_INVERT  (LEFT_INVERT),
        .RIGHT_INVERT (RIGHT_INVERT)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_duty     (left_duty),
        .left_forward  (left_forward),
        .right_duty    (right_duty),
        .right_forward (right_forward),
        .spin_active   (spin_active),
        .alu_req       (alu_req),
        .alu_rsp       (alu_rsp)
    );

    twdm_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

endmodule

// ===== rtl/twdm_checker.sv =====
// ----------------------------------------------------------------------------
// twdm_checker
// port level checks of the mixer, bound to the top level
// ----------------------------------------------------------------------------
`include "twist_to_wheel_duty_mixer_unit_defines.svh"

module twdm_checker
    import twdm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DUTY_W-1:0] left_duty,
    input logic              left_forward,
    input logic [DUTY_W-1:0] right_duty,
    input logic              right_forward,
    input logic              spin_active
);

    // stalled result holds
    `TWDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_duty) && $stable(right_duty) && $stable(left_forward) && $stable(right_forward) && $stable(spin_active))

    // one command at a time
    `TWDM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // loading a result frees the input side
    `TWDM_ASSERT_IMP(a_result_frees_input, $rose(out_valid), in_ready)

    // an idle block stays idle without a command
    `TWDM_ASSERT_NEXT(a_idle_holds, in_ready && !in_valid, in_ready)

endmodule

bind twist_to_wheel_duty_mixer_unit twdm_checker u_twdm_checker (.*);

// ===== dv/wheel_duty_checker.sv =====
// ----------------------------------------------------------------------------
// wheel_duty_checker
// follows the register writes and command transactions of the mixer, works
// out the wheel duties, directions and spin flag that each command should
// give, and compares every result transaction with the oldest expectation
// ----------------------------------------------------------------------------
module wheel_duty_checker
    import twdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [SPEED_W-1:0]    linear_speed,
    input  logic [SPEED_W-1:0]    angular_speed,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [DUTY_W-1:0]     left_duty,
    input  logic                  left_forward,
    input  logic [DUTY_W-1:0]     right_duty,
    input  logic                  right_forward,
    input  logic                  spin_active,
    output int                    fail_count,
    output int                    pending,
    output int                    checked,
    output int                    spins
);

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic              left_forward;
        logic [DUTY_W-1:0] right_duty;
        logic              right_forward;
        logic              spin_active;
    } wheel_duty_t;

    cfg_t                      settings;
    logic signed [SPEED_W-1:0] left_filt;
    logic signed [SPEED_W-1:0] right_filt;
    wheel_duty_t               duty_expect_q[$];
    int                        fails;
    int                        results;
    int                        spin_total;

    // floor((x + 2^(s-1)) / 2^s)
    function automatic longint round_q(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_wheel(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    function automatic longint smooth(input longint prev, input longint target);
        longint a;
        a = (settings.alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(settings.alpha);
        return prev + round_q(a * (target - prev), 8);
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of_cmd(input longint cmd, input bit spin);
        longint mag;
        longint lim;
        longint dvs;
        longint d;
        longint fl;
        mag = (cmd < 0) ? -cmd : cmd;
        lim = longint'(settings.max_speed);
        dvs = (lim == 0) ? 1 : lim;
        if (mag > lim)
            mag = lim;
        d = (mag * 510 + dvs) / (2 * dvs);
        if (d > 255)
            d = 255;
        fl = spin ? longint'(settings.floors[15:8]) : longint'(settings.floors[7:0]);
        if (d > 0 && d < fl)
            d = fl;
        return d[DUTY_W-1:0];
    endfunction

    // advances the wheel filters and returns the result of one command
    function automatic wheel_duty_t predict_wheel_duty(input logic [SPEED_W-1:0] lin_raw,
                                                       input logic [SPEED_W-1:0] ang_raw);
        longint      v;
        longint      wz;
        longint      w;
        longint      h;
        longint      vl;
        longint      vr;
        longint      t;
        longint      lc;
        longint      rc;
        bit          spin;
        wheel_duty_t r;
        v  = longint'($signed(lin_raw));
        wz = longint'($signed(ang_raw));
        if (((v < 0) ? -v : v) < longint'(settings.linear_db))
            v = 0;
        if (((wz < 0) ? -wz : wz) < longint'(settings.angular_db))
            wz = 0;
        w  = round_q(longint'($signed(settings.gain)) * wz, 12);
        h  = round_q(w * longint'(settings.half_track), 12);
        vl = v - h;
        vr = v + h;
        spin = (v == 0) && (w != 0);
        if (spin)
        begin
            t = (h < 0) ? -h : h;
            if (t < longint'(settings.spin_floor))
                t = longint'(settings.spin_floor);
            if (w > 0)
            begin
                vl = -t;
                vr = t;
            end
            else
            begin
                vl = t;
                vr = -t;
            end
        end
        vl = clamp_wheel(vl, longint'(settings.max_speed));
        vr = clamp_wheel(vr, longint'(settings.max_speed));
        left_filt  = 16'(smooth(longint'(left_filt), vl));
        right_filt = 16'(smooth(longint'(right_filt), vr));
        lc = DEF_LEFT_INVERT ? -longint'(left_filt) : longint'(left_filt);
        rc = DEF_RIGHT_INVERT ? -longint'(right_filt) : longint'(right_filt);
        r.left_duty     = duty_of_cmd(lc, spin);
        r.left_forward  = (lc >= 0);
        r.right_duty    = duty_of_cmd(rc, spin);
        r.right_forward = (rc >= 0);
        r.spin_active   = spin;
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        wheel_duty_t want;
        if (!rst_n)
        begin
            settings.linear_db  = RST_LINEAR_DB;
            settings.angular_db = RST_ANGULAR_DB;
            settings.gain       = RST_GAIN;
            settings.half_track = RST_HALF_TRACK;
            settings.spin_floor = RST_SPIN_FLOOR;
            settings.max_speed  = RST_MAX_SPEED;
            settings.alpha      = RST_ALPHA;
            settings.floors     = RST_FLOORS;
            left_filt  = '0;
            right_filt = '0;
            duty_expect_q.delete();
            fails      = 0;
            results    = 0;
            spin_total = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_LINEAR_DB:  settings.linear_db  = cfg_data[DB_W-1:0];
                    CFG_ANGULAR_DB: settings.angular_db = cfg_data[DB_W-1:0];
                    CFG_GAIN:       settings.gain       = cfg_data[GAIN_W-1:0];
                    CFG_HALF_TRACK: settings.half_track = cfg_data[TRACK_W-1:0];
                    CFG_SPIN_FLOOR: settings.spin_floor = cfg_data[DB_W-1:0];
                    CFG_MAX_SPEED:  settings.max_speed  = cfg_data[DB_W-1:0];
                    CFG_ALPHA:      settings.alpha      = cfg_data[ALPHA_W-1:0];
                    CFG_FLOORS:     settings.floors     = cfg_data[FLOORS_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                want = predict_wheel_duty(linear_speed, angular_speed);
                if (want.spin_active)
                    spin_total++;
                duty_expect_q.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (duty_expect_q.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    fails++;
                end
                else
                begin
                    want = duty_expect_q.pop_front();
                    check_field("left_duty", want.left_duty, left_duty);
                    check_field("left_forward", want.left_forward, left_forward);
                    check_field("right_duty", want.right_duty, right_duty);
                    check_field("right_forward", want.right_forward, right_forward);
                    check_field("spin_active", want.spin_active, spin_active);
                    results++;
                end
            end
        end
        fail_count <= fails;
        pending    <= duty_expect_q.size();
        checked    <= results;
        spins      <= spin_total;
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives the twist to wheel duty mixer through directed corner commands and
// random command traffic under a series of register settings, with bursty
// input, a stalling output side and one long output hold-off
// ----------------------------------------------------------------------------
module tb;
    import twdm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int DIRECTED_N     = 24;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [SPEED_W-1:0]    linear_speed  = '0;
    logic [SPEED_W-1:0]    angular_speed = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [DUTY_W-1:0]     left_duty;
    logic                  left_forward;
    logic [DUTY_W-1:0]     right_duty;
    logic                  right_forward;
    logic                  spin_active;

    int fail_count;
    int pending;
    int checked;
    int spins;
    int sent        = 0;
    int phases      = 0;
    int idle_cycles = 0;
    int cur_lin_db  = int'(RST_LINEAR_DB);
    int cur_ang_db  = int'(RST_ANGULAR_DB);

    int dir_lin [DIRECTED_N] = '{0, 32767, -32768, 0, 0, 32767, -32768, 32767,
                                 82, 81, -82, -81, 0, 0, 0, 0,
                                 0, 0, 40, 4096, -4096, 2000, 0, 0};
    int dir_ang [DIRECTED_N] = '{0, 0, 0, 32767, -32768, 32767, -32768, -32768,
                                 0, 0, 0, 0, 205, 204, -205, -204,
                                 300, -300, 1000, 2048, -2048, -500, 0, 0};

    always #5 clk = ~clk;

    twist_to_wheel_duty_mixer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_duty     (left_duty),
        .left_forward  (left_forward),
        .right_duty    (right_duty),
        .right_forward (right_forward),
        .spin_active   (spin_active)
    );

    wheel_duty_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_duty     (left_duty),
        .left_forward  (left_forward),
        .right_duty    (right_duty),
        .right_forward (right_forward),
        .spin_active   (spin_active),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .spins         (spins)
    );

    task automatic send_twist(input logic [SPEED_W-1:0] lin, input logic [SPEED_W-1:0] ang);
        in_valid      <= 1'b1;
        linear_speed  <= lin;
        angular_speed <= ang;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_LINEAR_DB)
            cur_lin_db = int'(value[DB_W-1:0]);
        if (idx == CFG_ANGULAR_DB)
            cur_ang_db = int'(value[DB_W-1:0]);
    endtask

    task automatic apply_settings(input logic [15:0] lin_db, input logic [15:0] ang_db,
                                  input logic [15:0] gain, input logic [15:0] track,
                                  input logic [15:0] sfloor, input logic [15:0] max_spd,
                                  input logic [15:0] alpha, input logic [15:0] floors);
        write_reg(CFG_LINEAR_DB, lin_db);
        write_reg(CFG_ANGULAR_DB, ang_db);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_HALF_TRACK, track);
        write_reg(CFG_SPIN_FLOOR, sfloor);
        write_reg(CFG_MAX_SPEED, max_spd);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_FLOORS, floors);
        cfg_write <= 1'b0;
        phases++;
    endtask

    task automatic random_settings();
        logic [15:0] max_spd;
        logic [15:0] alpha;
        max_spd = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 32767))
                                              : 16'($urandom_range(200, 4000));
        alpha   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 511))
                                              : 16'($urandom_range(16, 256));
        apply_settings(16'($urandom_range(0, 600)), 16'($urandom_range(0, 800)),
                       16'($urandom), 16'($urandom_range(0, 4095)),
                       16'($urandom_range(0, 3000)), max_spd, alpha, 16'($urandom));
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [SPEED_W-1:0] near_edge(input int db);
        int x;
        x = $urandom_range(0, 1) ? db : db - 1;
        if ($urandom_range(0, 1))
            x = -x;
        return x[SPEED_W-1:0];
    endfunction

    function automatic logic [SPEED_W-1:0] extreme_speed();
        case ($urandom_range(0, 4))
            0:       return 16'sd32767;
            1:       return 16'h8000;
            2:       return 16'd1;
            3:       return 16'hFFFF;
            default: return 16'd0;
        endcase
    endfunction

    task automatic pick_twist(output logic [SPEED_W-1:0] lin, output logic [SPEED_W-1:0] ang);
        int k;
        int x;
        k = $urandom_range(0, 99);
        lin = 16'($urandom);
        ang = 16'($urandom);
        if (k < 30)
            return;
        if (k < 52)
        begin
            // pure angular, linear zero or lost in its deadband
            x = (cur_lin_db > 0 && $urandom_range(0, 1)) ? $urandom_range(0, cur_lin_db - 1) : 0;
            lin = $urandom_range(0, 1) ? x[15:0] : 16'(-x);
            if ($urandom_range(0, 1))
                ang = 16'($signed(16'($urandom_range(0, 8191))) - 16'sd4096);
        end
        else if (k < 62)
            ang = '0;
        else if (k < 76)
        begin
            lin = $urandom_range(0, 2) ? near_edge(cur_lin_db) : 16'd0;
            ang = $urandom_range(0, 2) ? near_edge(cur_ang_db) : 16'd0;
        end
        else if (k < 86)
        begin
            lin = extreme_speed();
            ang = extreme_speed();
        end
        else
        begin
            lin = 16'($signed(16'($urandom_range(0, 8191))) - 16'sd4096);
            ang = 16'($signed(16'($urandom_range(0, 8191))) - 16'sd4096);
        end
    endtask

    // bursts of commands with random gaps, some bursts run straight on
    task automatic drive_commands(input int count);
        int               remaining;
        int               burst;
        int               gap;
        logic [SPEED_W-1:0] lin;
        logic [SPEED_W-1:0] ang;
        remaining = count;
        while (remaining > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > remaining)
                burst = remaining;
            repeat (burst)
            begin
                pick_twist(lin, ang);
                send_twist(lin, ang);
            end
            remaining -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_twist(dir_lin[i][15:0], dir_ang[i][15:0]);
        in_valid <= 1'b0;
        drive_commands(260);

        // widest gain, track and clamp, no smoothing, no duty floors
        wait_drained();
        apply_settings(16'd0, 16'd0, 16'sd32767, 16'd4095, 16'd0, 16'd32767,
                       16'd256, 16'h0000);
        drive_commands(170);

        // deadbands at the top, alpha beyond one, clamp at one step
        wait_drained();
        apply_settings(16'd32767, 16'd32767, 16'h8000, 16'd4095, 16'd32767, 16'd1,
                       16'd511, 16'hFFFF);
        drive_commands(80);

        // load the filters up high before freezing them
        wait_drained();
        apply_settings(16'd0, 16'd0, 16'hD000, 16'd246, 16'd328, 16'd32767,
                       16'd256, 16'h501E);
        drive_commands(60);

        // frozen filter above a low clamp, zero gain means no spin
        wait_drained();
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd500, 16'd100, 16'd0, 16'h5020);
        drive_commands(60);

        // clamp at zero and zero half track
        wait_drained();
        apply_settings(16'd10, 16'd10, 16'd4096, 16'd0, 16'd200, 16'd0, 16'd128, 16'h3010);
        drive_commands(40);

        repeat (4)
        begin
            wait_drained();
            random_settings();
            drive_commands(100);
        end

        wait_drained();
        repeat (40)
            @(posedge clk);
        $display("covered %0d commands over %0d register settings plus reset values",
                 sent, phases);
        $display("%0d results compared, %0d of them in-place spins", checked, spins);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // output side stalls on its own pattern, with one long hold-off
    initial
    begin : receiver
        int  mode;
        bit  held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && checked >= 100)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge clk);
            end
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(40, 120))
                    @(posedge clk);
            end
            else if (mode < 6)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16))
                    @(posedge clk);
            end
            else if (mode < 9)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5))
                    @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(6, 24))
                    @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
